// ----- src/gpd_pkg.sv -----
// Shared constants, types and register map of the Gaussian pyramid reduce block.
package gpd_pkg;

  // Image geometry
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int SIZE_W     = 11;
  localparam int PIX_W      = 8;

  // Filter window: five taps, four stored lines
  localparam int WIN        = 5;
  localparam int LB_LINES   = WIN - 1;
  localparam int TAP_W      = 3;
  localparam int VSUM_W     = 13;
  localparam int HSUM_W     = 17;

  // Divide by 400 as a shift by 4 and a reciprocal multiply for 25
  localparam int DIV_PRE_SHIFT = 4;
  localparam int RECIP         = 5243;
  localparam int RECIP_SHIFT   = 17;
  localparam int PROD_W        = 26;
  localparam int DIVISOR       = 400;
  localparam int HALF          = 200;

  // Register file
  localparam int APB_DW       = 32;
  localparam int PADDR_W      = 3;
  localparam int REG_IDX_W    = 1;
  localparam logic [SIZE_W-1:0] RESET_WIDTH  = SIZE_W'(640);
  localparam logic [SIZE_W-1:0] RESET_HEIGHT = SIZE_W'(480);
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  typedef logic [LB_LINES-1:0][PIX_W-1:0] lb_word_t;

  typedef struct packed {
    logic [COL_W:0] width;    // width in use, saturated
    logic [ROW_W:0] height;   // height in use, saturated
    logic           restart;  // register write this cycle
  } cfg_t;

endpackage

// ----- src/gaussian_pyramid_downsample_top.sv -----
// Top level: one 5x5 Gaussian reduce level over a raster pixel stream.
//
// Pixels of one image enter on in_pixel_in in raster order, one beat per
// accepted in_valid/!in_stall. For every input beat that completes a 5x5
// window centred on an even row and column, one beat leaves on out_pixel_out,
// so the result is an image of floor(w/2) x floor(h/2); out_frame_last marks
// its last pixel. Edge rows and columns are replicated at the borders.
// Sizes are set over APB (image_width at 0x0, image_height at 0x4); any write
// restarts the image at the next pixel; the user, unchecked by the block,
// makes writes only while the block idles. Throughput: one pixel per cycle
// unless out_stall holds the pipeline, set by the single read/write port pair
// of each line memory. A beat passes stage A (line read), B (vertical sum), C
// (horizontal sum), D (reciprocal multiply) and the output (rounding). A stage
// holds its beat while the next one is held, so in_stall rises only once the
// stages behind a stalled output are all occupied. Reset empties the pipeline,
// zeroes row and column counters, loads 640 x 480; line memories keep data.
module gaussian_pyramid_downsample_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [gpd_pkg::PIX_W-1:0]   in_pixel_in,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [gpd_pkg::PIX_W-1:0]   out_pixel_out,
  output logic                        out_frame_last,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gpd_pkg::PADDR_W-1:0] paddr,
  input  logic [gpd_pkg::APB_DW-1:0]  pwdata,
  output logic [gpd_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);
  import gpd_pkg::*;

  // Weighted 5-tap sum [1,5,8,5,1]; x0 is the newest sample. Samples older
  // than the image edge are replaced by the oldest valid one. At the far edge
  // (odd position) the window is [0,1,5,8,5+1].
  function automatic logic [HSUM_W-1:0] tap5(
    input logic [VSUM_W-1:0] x0,
    input logic [VSUM_W-1:0] x1,
    input logic [VSUM_W-1:0] x2,
    input logic [VSUM_W-1:0] x3,
    input logic [VSUM_W-1:0] x4,
    input logic [TAP_W-1:0]  n,
    input logic              odd
  );
    logic [HSUM_W-1:0] e0, e1, e2, e3, e4;
    logic [HSUM_W-1:0] s;
    e0 = HSUM_W'(x0);
    e1 = (n >= TAP_W'(1)) ? HSUM_W'(x1) : e0;
    e2 = (n >= TAP_W'(2)) ? HSUM_W'(x2) : e1;
    e3 = (n >= TAP_W'(3)) ? HSUM_W'(x3) : e2;
    e4 = (n >= TAP_W'(4)) ? HSUM_W'(x4) : e3;
    if (odd) begin
      s = e3 + (e2 << 2) + e2 + (e1 << 3) + (e0 << 2) + (e0 << 1);
    end else begin
      s = e4 + (e3 << 2) + e3 + (e2 << 3) + (e1 << 2) + e1 + e0;
    end
    return s;
  endfunction

  cfg_t cfg;

  gpd_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Stage enables: a stage may load when it is empty or its beat moves on
  logic en_a, en_b, en_c, en_d, en_o, acc;
  logic a_v_r, b_v_r, c_v_r, d_v_r, out_v_r;

  assign en_o     = !out_v_r || !out_stall;
  assign en_d     = !d_v_r || en_o;
  assign en_c     = !c_v_r || en_d;
  assign en_b     = !b_v_r || en_c;
  assign en_a     = !a_v_r || en_b;
  assign in_stall = !en_a;
  assign acc      = in_valid && en_a;

  // Position counters
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             col_end, row_end;

  assign col_end = ({1'b0, col_r} == cfg.width - 1'b1);
  assign row_end = ({1'b0, row_r} == cfg.height - 1'b1);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (acc) begin
      if (col_end) begin
        col_nxt = '0;
        row_nxt = row_end ? '0 : row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg.restart) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Window position of the incoming pixel
  logic             row_trig, col_trig;
  logic [TAP_W-1:0] rtap, ctap;

  assign row_trig = row_r[0] ? row_end : (row_r >= ROW_W'(2));
  assign col_trig = col_r[0] ? col_end : (col_r >= COL_W'(2));
  assign rtap     = (row_r >= ROW_W'(4)) ? TAP_W'(4) : row_r[TAP_W-1:0];
  assign ctap     = (col_r >= COL_W'(4)) ? TAP_W'(4) : col_r[TAP_W-1:0];

  // Stage A: pixel plus the four rows above it from the line memories
  logic [PIX_W-1:0] a_pix_r;
  logic [COL_W-1:0] a_col_r;
  logic [TAP_W-1:0] a_rtap_r, a_ctap_r;
  logic             a_rodd_r, a_codd_r, a_trig_r, a_last_r;
  lb_word_t         lb_rd, lb_wr;
  logic             lb_we;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (en_a) begin
      a_v_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      a_pix_r  <= in_pixel_in;
      a_col_r  <= col_r;
      a_rtap_r <= rtap;
      a_ctap_r <= ctap;
      a_rodd_r <= row_r[0];
      a_codd_r <= col_r[0];
      a_trig_r <= row_trig && col_trig;
      a_last_r <= row_end && col_end;
    end
  end

  // Shift the column down one line as the beat leaves stage A
  assign lb_we = a_v_r && en_b;

  always_comb begin
    lb_wr[0] = a_pix_r;
    for (int k = 1; k < LB_LINES; k++) begin
      lb_wr[k] = lb_rd[k-1];
    end
  end

  gpd_line_buf u_line_buf (
    .clk     (clk),
    .rd_en   (acc),
    .rd_addr (col_r),
    .rd_data (lb_rd),
    .wr_en   (lb_we),
    .wr_addr (a_col_r),
    .wr_data (lb_wr)
  );

  // Stage B: vertical sum of the column
  logic [VSUM_W-1:0] vsum_a;
  logic [VSUM_W-1:0] b_vsum_r;
  logic [TAP_W-1:0]  b_ctap_r;
  logic              b_codd_r, b_trig_r, b_last_r;

  assign vsum_a = VSUM_W'(tap5(VSUM_W'(a_pix_r), VSUM_W'(lb_rd[0]), VSUM_W'(lb_rd[1]),
                               VSUM_W'(lb_rd[2]), VSUM_W'(lb_rd[3]), a_rtap_r, a_rodd_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (en_b) begin
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (lb_we) begin
      b_vsum_r <= vsum_a;
      b_ctap_r <= a_ctap_r;
      b_codd_r <= a_codd_r;
      b_trig_r <= a_trig_r;
      b_last_r <= a_last_r;
    end
  end

  // Stage C: horizontal sum over the last five column sums
  logic [VSUM_W-1:0] hist_r [LB_LINES];
  logic [HSUM_W-1:0] hsum_b;
  logic [HSUM_W-1:0] c_hsum_r;
  logic              c_last_r;
  logic              b_pop;

  assign b_pop  = b_v_r && en_c;
  assign hsum_b = tap5(b_vsum_r, hist_r[0], hist_r[1], hist_r[2], hist_r[3],
                       b_ctap_r, b_codd_r);

  always_ff @(posedge clk) begin
    if (b_pop) begin
      hist_r[0] <= b_vsum_r;
      for (int k = 1; k < LB_LINES; k++) begin
        hist_r[k] <= hist_r[k-1];
      end
    end
  end

  // Drop beats that complete no window
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else if (en_c) begin
      c_v_r <= b_v_r && b_trig_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_pop) begin
      c_hsum_r <= hsum_b;
      c_last_r <= b_last_r;
    end
  end

  // Stage D: quotient by 400 as (sum >> 4) * ceil(2^17 / 25) >> 17
  logic [PROD_W-1:0] prod_c;
  logic [PIX_W-1:0]  d_q_r;
  logic [HSUM_W-1:0] d_sum_r;
  logic              d_last_r;

  assign prod_c = PROD_W'(c_hsum_r[HSUM_W-1:DIV_PRE_SHIFT]) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_v_r <= 1'b0;
    end else if (en_d) begin
      d_v_r <= c_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (c_v_r && en_d) begin
      d_q_r    <= prod_c[RECIP_SHIFT +: PIX_W];
      d_sum_r  <= c_hsum_r;
      d_last_r <= c_last_r;
    end
  end

  // Output stage: round to nearest, ties to even
  logic [HSUM_W-1:0] qm_d, rem_d;
  logic              round_up;
  logic [PIX_W:0]    q_inc;
  logic [PIX_W-1:0]  pix_d;
  logic [PIX_W-1:0]  out_pix_r;
  logic              out_last_r;

  assign qm_d     = HSUM_W'(d_q_r) * HSUM_W'(DIVISOR);
  assign rem_d    = d_sum_r - qm_d;
  assign round_up = (rem_d > HSUM_W'(HALF)) || ((rem_d == HSUM_W'(HALF)) && d_q_r[0]);
  assign q_inc    = {1'b0, d_q_r} + (PIX_W+1)'(round_up);
  assign pix_d    = q_inc[PIX_W] ? {PIX_W{1'b1}} : q_inc[PIX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en_o) begin
      out_v_r <= d_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (d_v_r && en_o) begin
      out_pix_r  <= pix_d;
      out_last_r <= d_last_r;
    end
  end

  assign out_valid      = out_v_r;
  assign out_pixel_out  = out_pix_r;
  assign out_frame_last = out_last_r;

endmodule

// ----- src/gpd_line_buf.sv -----
// Four line memories that delay the pixel stream by one to four rows.
module gpd_line_buf (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [gpd_pkg::COL_W-1:0] rd_addr,
  output gpd_pkg::lb_word_t        rd_data,
  input  logic                     wr_en,
  input  logic [gpd_pkg::COL_W-1:0] wr_addr,
  input  gpd_pkg::lb_word_t        wr_data
);
  import gpd_pkg::*;

  logic [PIX_W-1:0] line_mem [LB_LINES][MAX_WIDTH];

  always_ff @(posedge clk) begin
    for (int k = 0; k < LB_LINES; k++) begin
      if (wr_en) begin
        line_mem[k][wr_addr] <= wr_data[k];
      end
      if (rd_en) begin
        rd_data[k] <= line_mem[k][rd_addr];
      end
    end
  end

endmodule

// ----- src/gpd_regs.sv -----
// APB register file for the image size, with saturation of the sizes in use.
module gpd_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gpd_pkg::PADDR_W-1:0] paddr,
  input  logic [gpd_pkg::APB_DW-1:0]  pwdata,
  output logic [gpd_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  output gpd_pkg::cfg_t               cfg
);
  import gpd_pkg::*;

  logic [SIZE_W-1:0]    width_r;
  logic [SIZE_W-1:0]    height_r;
  logic                 wr_strobe;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready    = 1'b1;
  assign wr_strobe = psel && penable && pwrite;
  assign reg_idx   = paddr[PADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RESET_WIDTH;
      height_r <= RESET_HEIGHT;
    end else if (wr_strobe) begin
      unique case (reg_idx)
        REG_IMAGE_WIDTH:  width_r  <= pwdata[SIZE_W-1:0];
        REG_IMAGE_HEIGHT: height_r <= pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_IMAGE_WIDTH:  prdata = APB_DW'(width_r);
      REG_IMAGE_HEIGHT: prdata = APB_DW'(height_r);
      default:          prdata = '0;
    endcase
  end

  // Clamp the sizes to what the line memories and counters can hold
  always_comb begin
    if (width_r < SIZE_W'(2)) begin
      cfg.width = (COL_W+1)'(2);
    end else if (int'(width_r) > MAX_WIDTH) begin
      cfg.width = (COL_W+1)'(MAX_WIDTH);
    end else begin
      cfg.width = (COL_W+1)'(width_r);
    end
    if (height_r < SIZE_W'(2)) begin
      cfg.height = (ROW_W+1)'(2);
    end else if (int'(height_r) > MAX_HEIGHT) begin
      cfg.height = (ROW_W+1)'(MAX_HEIGHT);
    end else begin
      cfg.height = (ROW_W+1)'(height_r);
    end
    cfg.restart = wr_strobe;
  end

endmodule
